### hw/rtl/ast_pkg.sv
// Shared types, constants and character-class helpers for the assembly source tokenizer.
package ast_pkg;

  localparam int unsigned MaxTokenLen = 255;
  localparam int unsigned OffsetBits  = 24;
  localparam int unsigned LineBits    = 16;
  localparam int unsigned QueueDepth  = 4;

  localparam int unsigned OutOffsetBits = 24;
  localparam int unsigned OutLineBits   = 16;
  localparam int unsigned OutLenBits    = 8;

  localparam logic [7:0] CharColon      = ":";
  localparam logic [7:0] CharComma      = ",";
  localparam logic [7:0] CharLBracket   = "[";
  localparam logic [7:0] CharRBracket   = "]";
  localparam logic [7:0] CharUnderscore = "_";
  localparam logic [7:0] CharSemicolon  = ";";
  localparam logic [7:0] CharNewline    = 8'h0A;
  localparam logic [7:0] CharZero       = "0";
  localparam logic [7:0] CharLowerX     = "x";
  localparam logic [7:0] CharUpperX     = "X";

  localparam logic [23:0] WordMov = "MOV";
  localparam logic [23:0] WordAdd = "ADD";
  localparam logic [23:0] WordSub = "SUB";
  localparam logic [23:0] WordDiv = "DIV";
  localparam logic [23:0] WordInt = "INT";

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_WORD    = 3'd2,
    MODE_ZERO    = 3'd3,
    MODE_DEC     = 3'd4,
    MODE_HEX     = 3'd5
  } scan_mode_e;

  typedef enum logic [2:0] {
    TOK_COLON    = 3'd0,
    TOK_COMMA    = 3'd1,
    TOK_LBRACKET = 3'd2,
    TOK_RBRACKET = 3'd3,
    TOK_KEYWORD  = 3'd4,
    TOK_WORD     = 3'd5,
    TOK_EOF      = 3'd6
  } token_kind_e;

  typedef enum logic [2:0] {
    KW_NONE = 3'd0,
    KW_MOV  = 3'd1,
    KW_ADD  = 3'd2,
    KW_SUB  = 3'd3,
    KW_DIV  = 3'd4,
    KW_INT  = 3'd5
  } keyword_e;

  typedef struct packed {
    token_kind_e              kind;
    keyword_e                 keyword;
    logic                     is_number;
    logic [OutOffsetBits-1:0] offset;
    logic [OutLineBits-1:0]   line;
    logic [OutLineBits-1:0]   column;
    logic [OutLenBits-1:0]    length;
    logic                     overflow;
  } token_t;

  // A word token that a byte closes comes first, then the token of the byte itself.
  typedef struct packed {
    logic   a_valid;
    token_t a;
    logic   b_valid;
    token_t b;
  } record_t;

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_dec(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_dec(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return (c == CharColon) || (c == CharComma) || (c == CharLBracket) ||
           (c == CharRBracket);
  endfunction

  function automatic token_kind_e punct_kind(logic [7:0] c);
    token_kind_e k;
    case (c)
      CharColon:    k = TOK_COLON;
      CharComma:    k = TOK_COMMA;
      CharLBracket: k = TOK_LBRACKET;
      default:      k = TOK_RBRACKET;
    endcase
    return k;
  endfunction

  function automatic keyword_e keyword_lookup(logic [23:0] w);
    keyword_e k;
    case (w)
      WordMov: k = KW_MOV;
      WordAdd: k = KW_ADD;
      WordSub: k = KW_SUB;
      WordDiv: k = KW_DIV;
      WordInt: k = KW_INT;
      default: k = KW_NONE;
    endcase
    return k;
  endfunction

endpackage

### hw/rtl/ast_front.sv
// Front end: accepts source bytes, tracks position and scan mode, and builds token records.
module ast_front #(
  parameter int unsigned MAX_TOKEN_LEN = ast_pkg::MaxTokenLen,
  parameter int unsigned OFFSET_BITS   = ast_pkg::OffsetBits,
  parameter int unsigned LINE_BITS     = ast_pkg::LineBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             kind_i,
  input  logic [7:0]       char_code_i,
  input  logic             queue_ready_i,
  output logic             push_o,
  output ast_pkg::record_t rec_o
);

  localparam int unsigned LenBits = $clog2(MAX_TOKEN_LEN + 2);
  localparam int unsigned OB = ast_pkg::OutOffsetBits;
  localparam int unsigned LB = ast_pkg::OutLineBits;
  localparam int unsigned NB = ast_pkg::OutLenBits;

  ast_pkg::scan_mode_e    mode_q, mode_d;
  logic [LINE_BITS-1:0]   line_q, line_d, col_q, col_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [LB-1:0]          wline_q, wline_d, wcol_q, wcol_d;
  logic [OB-1:0]          woff_q, woff_d;
  logic [LenBits-1:0]     wlen_q, wlen_d;
  logic [23:0]            prefix_q, prefix_d;

  logic                   fire;
  logic                   word_active;
  logic                   cont;
  ast_pkg::scan_mode_e    cont_mode;
  logic                   newline;
  logic [LINE_BITS-1:0]   line_adv, col_adv;
  logic [OFFSET_BITS-1:0] off_adv;
  logic [OFFSET_BITS+OB-1:0] off_ext;
  logic [LINE_BITS+LB-1:0]   line_ext, col_ext;
  logic [LenBits-1:0]     len_shown;
  logic [LenBits+NB-1:0]  len_ext;
  ast_pkg::keyword_e      kw;
  ast_pkg::token_t        word_tok, here_tok;
  ast_pkg::record_t       rec;

  assign fire       = in_valid_i & queue_ready_i;
  assign in_ready_o = queue_ready_i;
  assign push_o     = fire & (rec.a_valid | rec.b_valid);
  assign rec_o      = rec;

  assign word_active = (mode_q == ast_pkg::MODE_WORD) || (mode_q == ast_pkg::MODE_ZERO) ||
                       (mode_q == ast_pkg::MODE_DEC) || (mode_q == ast_pkg::MODE_HEX);

  assign newline  = (char_code_i == ast_pkg::CharNewline);
  assign line_adv = (newline && (line_q != '1)) ? line_q + LINE_BITS'(1) : line_q;
  assign col_adv  = newline ? LINE_BITS'(1) : ((col_q != '1) ? col_q + LINE_BITS'(1) : col_q);
  assign off_adv  = (off_q != '1) ? off_q + OFFSET_BITS'(1) : off_q;

  assign off_ext  = {{OB{1'b0}}, off_q};
  assign line_ext = {{LB{1'b0}}, line_q};
  assign col_ext  = {{LB{1'b0}}, col_q};

  assign len_shown = (wlen_q > LenBits'(MAX_TOKEN_LEN)) ? LenBits'(MAX_TOKEN_LEN) : wlen_q;
  assign len_ext   = {{NB{1'b0}}, len_shown};

  assign kw = ((mode_q == ast_pkg::MODE_WORD) && (wlen_q == LenBits'(3))) ?
              ast_pkg::keyword_lookup(prefix_q) : ast_pkg::KW_NONE;

  always_comb begin
    word_tok           = '0;
    word_tok.kind      = (kw != ast_pkg::KW_NONE) ? ast_pkg::TOK_KEYWORD : ast_pkg::TOK_WORD;
    word_tok.keyword   = kw;
    word_tok.is_number = (mode_q != ast_pkg::MODE_WORD);
    word_tok.offset    = woff_q;
    word_tok.line      = wline_q;
    word_tok.column    = wcol_q;
    word_tok.length    = len_ext[NB-1:0];
    word_tok.overflow  = (wlen_q > LenBits'(MAX_TOKEN_LEN));

    here_tok           = '0;
    here_tok.kind      = ast_pkg::TOK_EOF;
    here_tok.keyword   = ast_pkg::KW_NONE;
    here_tok.offset    = off_ext[OB-1:0];
    here_tok.line      = line_ext[LB-1:0];
    here_tok.column    = col_ext[LB-1:0];
  end

  always_comb begin
    cont      = 1'b0;
    cont_mode = mode_q;
    case (mode_q)
      ast_pkg::MODE_WORD: begin
        cont = ast_pkg::is_letter(char_code_i) || ast_pkg::is_dec(char_code_i) ||
               (char_code_i == ast_pkg::CharUnderscore);
      end
      ast_pkg::MODE_ZERO: begin
        if ((char_code_i == ast_pkg::CharLowerX) || (char_code_i == ast_pkg::CharUpperX)) begin
          cont      = 1'b1;
          cont_mode = ast_pkg::MODE_HEX;
        end else if (ast_pkg::is_dec(char_code_i)) begin
          cont      = 1'b1;
          cont_mode = ast_pkg::MODE_DEC;
        end
      end
      ast_pkg::MODE_DEC: cont = ast_pkg::is_dec(char_code_i);
      ast_pkg::MODE_HEX: cont = ast_pkg::is_hex(char_code_i);
      default:           cont = 1'b0;
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    line_d   = line_q;
    col_d    = col_q;
    off_d    = off_q;
    wline_d  = wline_q;
    wcol_d   = wcol_q;
    woff_d   = woff_q;
    wlen_d   = wlen_q;
    prefix_d = prefix_q;
    rec      = '0;
    rec.a    = word_tok;
    rec.b    = here_tok;

    if (fire) begin
      if (kind_i) begin
        rec.a_valid     = word_active;
        rec.b_valid     = 1'b1;
        mode_d   = ast_pkg::MODE_IDLE;
        line_d   = LINE_BITS'(1);
        col_d    = LINE_BITS'(1);
        off_d    = '0;
        wline_d  = LB'(1);
        wcol_d   = LB'(1);
        woff_d   = '0;
        wlen_d   = '0;
        prefix_d = '0;
      end else if (mode_q == ast_pkg::MODE_COMMENT) begin
        if (newline) begin
          mode_d = ast_pkg::MODE_IDLE;
        end
        line_d = line_adv;
        col_d  = col_adv;
        off_d  = off_adv;
      end else if (word_active && cont) begin
        mode_d = cont_mode;
        if (wlen_q < LenBits'(3)) begin
          prefix_d = {prefix_q[15:0], char_code_i};
        end
        if (wlen_q <= LenBits'(MAX_TOKEN_LEN)) begin
          wlen_d = wlen_q + LenBits'(1);
        end
        line_d = line_adv;
        col_d  = col_adv;
        off_d  = off_adv;
      end else begin
        rec.a_valid = word_active;
        mode_d      = ast_pkg::MODE_IDLE;
        if (ast_pkg::is_punct(char_code_i)) begin
          rec.b_valid     = 1'b1;
          rec.b.kind      = ast_pkg::punct_kind(char_code_i);
          rec.b.length    = NB'(1);
        end else if (char_code_i == ast_pkg::CharSemicolon) begin
          mode_d = ast_pkg::MODE_COMMENT;
        end else if (ast_pkg::is_dec(char_code_i) || ast_pkg::is_letter(char_code_i) ||
                     (char_code_i == ast_pkg::CharUnderscore)) begin
          if (char_code_i == ast_pkg::CharZero) begin
            mode_d = ast_pkg::MODE_ZERO;
          end else if (ast_pkg::is_dec(char_code_i)) begin
            mode_d = ast_pkg::MODE_DEC;
          end else begin
            mode_d = ast_pkg::MODE_WORD;
          end
          wline_d  = line_ext[LB-1:0];
          wcol_d   = col_ext[LB-1:0];
          woff_d   = off_ext[OB-1:0];
          wlen_d   = LenBits'(1);
          prefix_d = {16'h0000, char_code_i};
        end
        line_d = line_adv;
        col_d  = col_adv;
        off_d  = off_adv;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ast_pkg::MODE_IDLE;
      line_q   <= LINE_BITS'(1);
      col_q    <= LINE_BITS'(1);
      off_q    <= '0;
      wline_q  <= LB'(1);
      wcol_q   <= LB'(1);
      woff_q   <= '0;
      wlen_q   <= '0;
      prefix_q <= '0;
    end else begin
      mode_q   <= mode_d;
      line_q   <= line_d;
      col_q    <= col_d;
      off_q    <= off_d;
      wline_q  <= wline_d;
      wcol_q   <= wcol_d;
      woff_q   <= woff_d;
      wlen_q   <= wlen_d;
      prefix_q <= prefix_d;
    end
  end

  a_comment_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !kind_i && (mode_q == ast_pkg::MODE_COMMENT)) |-> (!rec.a_valid && !rec.b_valid))
    else $error("A byte inside a comment produced a token.");

  a_eof_emitted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && kind_i) |-> (rec.b_valid && (rec.b.kind == ast_pkg::TOK_EOF)))
    else $error("End of input did not produce an eof token.");

  a_eof_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && kind_i) |=> ((mode_q == ast_pkg::MODE_IDLE) && (off_q == '0)))
    else $error("Scanner state was not cleared after end of input.");

endmodule

### hw/rtl/ast_queue.sv
// Small register queue of token records between the front end and the back end.
module ast_queue #(
  parameter int unsigned DEPTH = ast_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ast_pkg::record_t push_data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output ast_pkg::record_t data_o
);

  localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(DEPTH + 1);

  ast_pkg::record_t     mem_q [DEPTH];
  logic [PtrBits-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign ready_o = (cnt_q != CntBits'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrBits'(DEPTH - 1)) ? '0 : wr_q + PtrBits'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrBits'(DEPTH - 1)) ? '0 : rd_q + PtrBits'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntBits'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(DEPTH))
    else $error("Queue count exceeds its depth.");

endmodule

### hw/rtl/ast_back.sv
// Back end: splits queued records into single tokens and holds them in the output register.
module ast_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  ast_pkg::record_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ast_pkg::token_t  out_tok_o,
  output logic             out_last_o
);

  logic            sel_q, sel_d;
  logic            valid_q, valid_d;
  ast_pkg::token_t tok_q, tok_d;
  logic            last_q, last_d;
  logic            take_a;
  logic            load;

  assign take_a = head_i.a_valid && !sel_q;
  assign load   = head_valid_i && (!valid_q || out_ready_i);
  assign pop_o  = load && !(take_a && head_i.b_valid);

  always_comb begin
    sel_d   = sel_q;
    valid_d = valid_q;
    tok_d   = tok_q;
    last_d  = last_q;
    if (load) begin
      valid_d = 1'b1;
      tok_d   = take_a ? head_i.a : head_i.b;
      last_d  = take_a ? !head_i.b_valid : 1'b1;
      sel_d   = take_a && head_i.b_valid;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q  <= tok_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      sel_q   <= sel_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_tok_o   = tok_q;
  assign out_last_o  = last_q;

  a_second_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> (head_valid_i && head_i.b_valid))
    else $error("Second token pending without a record holding one.");

  a_split_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && take_a && head_i.b_valid) |=> (sel_q && valid_q && !out_last_o))
    else $error("First token of a two-token record was not followed by the second.");

endmodule

### hw/rtl/assembly_source_tokenizer.sv
// Top level of the assembly source tokenizer: front end, record queue and back end.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------------
//   input    | in_valid_i/in_ready_o| kind_i, char_code_i
//   output   | out_valid_o/out_ready_i | token_kind_o, keyword_code_o, is_number_o,
//            |                      | start_offset_o, line_number_o, column_number_o,
//            |                      | token_length_o, length_overflow_o, last_result_o
//
// One byte is taken per cycle while the record queue has room; a byte that closes a word
// and forms a token of its own yields two tokens, which leave one per cycle while
// out_ready_i is high. Each token passes the record queue, then the output register.
// The four-entry record queue lets the input run on while the output is stalled.
// Reset clears position, scan mode, queue and output register; no clearing pass follows.
module assembly_source_tokenizer #(
  parameter int unsigned MAX_TOKEN_LEN = ast_pkg::MaxTokenLen,
  parameter int unsigned OFFSET_BITS   = ast_pkg::OffsetBits,
  parameter int unsigned LINE_BITS     = ast_pkg::LineBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  token_kind_o,
  output logic [2:0]  keyword_code_o,
  output logic        is_number_o,
  output logic [23:0] start_offset_o,
  output logic [15:0] line_number_o,
  output logic [15:0] column_number_o,
  output logic [7:0]  token_length_o,
  output logic        length_overflow_o,
  output logic        last_result_o
);

  logic             q_ready, q_push, q_valid, q_pop;
  ast_pkg::record_t push_rec, head_rec;
  ast_pkg::token_t  out_tok;

  ast_front #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
    .OFFSET_BITS  (OFFSET_BITS),
    .LINE_BITS    (LINE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .char_code_i  (char_code_i),
    .queue_ready_i(q_ready),
    .push_o       (q_push),
    .rec_o        (push_rec)
  );

  ast_queue #(
    .DEPTH(ast_pkg::QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(push_rec),
    .ready_o    (q_ready),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .data_o     (head_rec)
  );

  ast_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(q_valid),
    .head_i      (head_rec),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_tok_o   (out_tok),
    .out_last_o  (last_result_o)
  );

  assign token_kind_o      = out_tok.kind;
  assign keyword_code_o    = out_tok.keyword;
  assign is_number_o       = out_tok.is_number;
  assign start_offset_o    = out_tok.offset;
  assign line_number_o     = out_tok.line;
  assign column_number_o   = out_tok.column;
  assign token_length_o    = out_tok.length;
  assign length_overflow_o = out_tok.overflow;

endmodule

### tb/assembly_source_tokenizer_test.sv
// Testbench for the assembly source tokenizer: random byte streams checked against a token predictor.
module assembly_source_tokenizer_test;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned IdlePercent = 29;
  localparam int unsigned RandomItems = 800;
  localparam int unsigned LenMax      = 255;
  localparam logic [15:0] LineMax     = 16'hFFFF;
  localparam logic [23:0] OffsetMax   = 24'hFFFFFF;

  typedef struct packed {
    logic       kind;
    logic [7:0] code;
  } src_item_t;

  typedef struct packed {
    ast_pkg::token_kind_e kind;
    ast_pkg::keyword_e    keyword;
    logic                 is_number;
    logic [23:0]          offset;
    logic [15:0]          line;
    logic [15:0]          column;
    logic [7:0]           length;
    logic                 overflow;
    logic                 last;
  } token_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        src_kind = 1'b0;
  logic [7:0]  src_code = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  tok_kind;
  logic [2:0]  tok_keyword;
  logic        tok_is_number;
  logic [23:0] tok_offset;
  logic [15:0] tok_line;
  logic [15:0] tok_column;
  logic [7:0]  tok_length;
  logic        tok_overflow;
  logic        tok_last;

  logic quiet = 1'b0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  int unsigned random_items = 0;

  src_item_t  byte_q[$];
  token_rec_t token_q[$];

  string KwNames[5] = '{"MOV", "ADD", "SUB", "DIV", "INT"};
  string FirstChars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_";
  string WordChars  = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789_";
  string HexChars   = "0123456789abcdefABCDEF";
  string PunctChars = ":,[]";

  // Scanner state mirrored by the predictor.
  ast_pkg::scan_mode_e scan = ast_pkg::MODE_IDLE;
  logic [15:0] cur_line = 16'd1;
  logic [15:0] cur_col = 16'd1;
  logic [23:0] cur_off = 24'd0;
  logic [15:0] word_line = 16'd1;
  logic [15:0] word_col = 16'd1;
  logic [23:0] word_off = 24'd0;
  logic [8:0]  word_len = 9'd0;
  logic [23:0] word_head = 24'd0;

  assembly_source_tokenizer dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .kind_i           (src_kind),
    .char_code_i      (src_code),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .token_kind_o     (tok_kind),
    .keyword_code_o   (tok_keyword),
    .is_number_o      (tok_is_number),
    .start_offset_o   (tok_offset),
    .line_number_o    (tok_line),
    .column_number_o  (tok_column),
    .token_length_o   (tok_length),
    .length_overflow_o(tok_overflow),
    .last_result_o    (tok_last)
  );

  function automatic logic alpha_byte(logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic digit_byte(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic hex_byte(logic [7:0] c);
    return digit_byte(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic void clear_scanner();
    scan = ast_pkg::MODE_IDLE;
    cur_line = 16'd1;
    cur_col = 16'd1;
    cur_off = 24'd0;
    word_line = 16'd1;
    word_col = 16'd1;
    word_off = 24'd0;
    word_len = 9'd0;
    word_head = 24'd0;
  endfunction

  function automatic void step_position(logic [7:0] c);
    if (c == ast_pkg::CharNewline) begin
      if (cur_line != LineMax) cur_line = cur_line + 16'd1;
      cur_col = 16'd1;
    end else if (cur_col != LineMax) begin
      cur_col = cur_col + 16'd1;
    end
    if (cur_off != OffsetMax) cur_off = cur_off + 24'd1;
  endfunction

  function automatic void grow_word(logic [7:0] c);
    if (word_len < 9'd3) word_head = {word_head[15:0], c};
    if (word_len <= LenMax) word_len = word_len + 9'd1;
  endfunction

  function automatic void open_word(ast_pkg::scan_mode_e m, logic [7:0] c);
    scan = m;
    word_line = cur_line;
    word_col = cur_col;
    word_off = cur_off;
    word_len = 9'd0;
    word_head = 24'd0;
    grow_word(c);
  endfunction

  function automatic token_rec_t make_token(ast_pkg::token_kind_e k, ast_pkg::keyword_e kw,
                                            logic num, logic [23:0] off, logic [15:0] line,
                                            logic [15:0] col, logic [8:0] len);
    token_rec_t t;
    t.kind = k;
    t.keyword = kw;
    t.is_number = num;
    t.offset = off;
    t.line = line;
    t.column = col;
    t.length = (len > LenMax) ? 8'hFF : len[7:0];
    t.overflow = (len > LenMax);
    t.last = 1'b0;
    return t;
  endfunction

  function automatic token_rec_t word_token();
    ast_pkg::keyword_e kw;
    kw = ast_pkg::KW_NONE;
    if ((scan == ast_pkg::MODE_WORD) && (word_len == 9'd3)) begin
      case (word_head)
        "MOV": kw = ast_pkg::KW_MOV;
        "ADD": kw = ast_pkg::KW_ADD;
        "SUB": kw = ast_pkg::KW_SUB;
        "DIV": kw = ast_pkg::KW_DIV;
        "INT": kw = ast_pkg::KW_INT;
        default: kw = ast_pkg::KW_NONE;
      endcase
    end
    return make_token((kw != ast_pkg::KW_NONE) ? ast_pkg::TOK_KEYWORD : ast_pkg::TOK_WORD,
                      kw, scan != ast_pkg::MODE_WORD, word_off, word_line, word_col,
                      word_len);
  endfunction

  // Works out the tokens that one accepted item causes and queues them in order.
  function automatic void tokenize_byte(logic k, logic [7:0] c);
    token_rec_t           res[2];
    int                   n;
    logic                 cont;
    ast_pkg::token_kind_e pk;
    n = 0;
    cont = 1'b0;
    if (k) begin
      if (scan >= ast_pkg::MODE_WORD) begin
        res[n] = word_token();
        n++;
      end
      res[n] = make_token(ast_pkg::TOK_EOF, ast_pkg::KW_NONE, 1'b0, cur_off, cur_line,
                          cur_col, 9'd0);
      n++;
      clear_scanner();
    end else if (scan == ast_pkg::MODE_COMMENT) begin
      if (c == ast_pkg::CharNewline) scan = ast_pkg::MODE_IDLE;
      step_position(c);
    end else begin
      case (scan)
        ast_pkg::MODE_WORD: cont = alpha_byte(c) || digit_byte(c) ||
                                   (c == ast_pkg::CharUnderscore);
        ast_pkg::MODE_ZERO: begin
          if ((c == ast_pkg::CharLowerX) || (c == ast_pkg::CharUpperX)) begin
            cont = 1'b1;
            scan = ast_pkg::MODE_HEX;
          end else if (digit_byte(c)) begin
            cont = 1'b1;
            scan = ast_pkg::MODE_DEC;
          end
        end
        ast_pkg::MODE_DEC: cont = digit_byte(c);
        ast_pkg::MODE_HEX: cont = hex_byte(c);
        default: cont = 1'b0;
      endcase
      if ((scan >= ast_pkg::MODE_WORD) && cont) begin
        grow_word(c);
        step_position(c);
      end else begin
        if (scan >= ast_pkg::MODE_WORD) begin
          res[n] = word_token();
          n++;
        end
        scan = ast_pkg::MODE_IDLE;
        if ((c == ast_pkg::CharColon) || (c == ast_pkg::CharComma) ||
            (c == ast_pkg::CharLBracket) || (c == ast_pkg::CharRBracket)) begin
          pk = (c == ast_pkg::CharColon) ? ast_pkg::TOK_COLON :
               (c == ast_pkg::CharComma) ? ast_pkg::TOK_COMMA :
               (c == ast_pkg::CharLBracket) ? ast_pkg::TOK_LBRACKET : ast_pkg::TOK_RBRACKET;
          res[n] = make_token(pk, ast_pkg::KW_NONE, 1'b0, cur_off, cur_line, cur_col, 9'd1);
          n++;
        end else if (c == ast_pkg::CharSemicolon) begin
          scan = ast_pkg::MODE_COMMENT;
        end else if (digit_byte(c)) begin
          open_word((c == ast_pkg::CharZero) ? ast_pkg::MODE_ZERO : ast_pkg::MODE_DEC, c);
        end else if (alpha_byte(c) || (c == ast_pkg::CharUnderscore)) begin
          open_word(ast_pkg::MODE_WORD, c);
        end
        step_position(c);
      end
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) res[i].last = 1'b1;
      token_q.push_back(res[i]);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  function automatic void push_byte(logic [7:0] c);
    src_item_t it;
    it.kind = 1'b0;
    it.code = c;
    byte_q.push_back(it);
    random_items++;
  endfunction

  function automatic void push_eof();
    src_item_t it;
    it.kind = 1'b1;
    it.code = 8'($urandom_range(0, 255));
    byte_q.push_back(it);
    random_items++;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void push_long_word(int len, logic numeric);
    push_byte(numeric ? 8'("1" + $urandom_range(0, 8)) : pick(FirstChars));
    for (int i = 1; i < len; i++) begin
      push_byte(numeric ? 8'("0" + $urandom_range(0, 9)) : pick(WordChars));
    end
  endfunction

  // Appends one random fragment of assembly source, mostly well formed.
  function automatic void push_piece();
    int    r;
    int    len;
    string kw;
    r = $urandom_range(0, 99);
    kw = KwNames[$urandom_range(0, 4)];
    if (r < 14) begin
      push_text(kw);
    end else if (r < 20) begin
      case ($urandom_range(0, 3))
        0: push_text(kw.tolower());
        1: push_text({kw, "X"});
        2: push_text(kw.substr(0, 1));
        default: begin
          push_text(kw);
          push_byte(8'("0" + $urandom_range(0, 9)));
        end
      endcase
    end else if (r < 32) begin
      push_byte(pick(FirstChars));
      len = $urandom_range(0, 7);
      for (int i = 0; i < len; i++) push_byte(pick(WordChars));
    end else if (r < 40) begin
      push_byte(8'("1" + $urandom_range(0, 8)));
      len = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) push_byte(8'("0" + $urandom_range(0, 9)));
    end else if (r < 48) begin
      push_byte(ast_pkg::CharZero);
      push_byte($urandom_range(0, 1) ? ast_pkg::CharLowerX : ast_pkg::CharUpperX);
      len = $urandom_range(0, 4);
      for (int i = 0; i < len; i++) push_byte(pick(HexChars));
    end else if (r < 52) begin
      push_byte(ast_pkg::CharZero);
      len = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) push_byte(8'("0" + $urandom_range(0, 9)));
    end else if (r < 55) begin
      push_byte(8'("0" + $urandom_range(0, 9)));
      push_byte(pick(FirstChars));
      push_byte(pick(WordChars));
    end else if (r < 70) begin
      push_byte(pick(PunctChars));
    end else if (r < 78) begin
      case ($urandom_range(0, 2))
        0: push_byte(" ");
        1: push_byte(8'h09);
        default: push_byte(8'h0D);
      endcase
    end else if (r < 86) begin
      push_byte(ast_pkg::CharNewline);
    end else if (r < 91) begin
      push_byte(ast_pkg::CharSemicolon);
      len = $urandom_range(0, 12);
      for (int i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)));
      push_byte(ast_pkg::CharNewline);
    end else if (r < 97) begin
      push_byte(8'($urandom_range(0, 255)));
    end else if (r < 99) begin
      push_eof();
    end else begin
      push_long_word($urandom_range(0, 3) == 0 ? 300 : $urandom_range(250, 260),
                     1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 9) < 6) push_byte(" ");
  endfunction

  task automatic wait_drained();
    while ((byte_q.size() != 0) || in_valid || (token_q.size() != 0)) @(negedge clk);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // Source driver: one item per transfer, valid held until accepted.
  always @(posedge clk) begin : source_driver
    src_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) tokenize_byte(src_kind, src_code);
      if (!in_valid || in_ready) begin
        if ((byte_q.size() != 0) && (quiet || ($urandom_range(0, 99) >= IdlePercent))) begin
          nxt = byte_q.pop_front();
          in_valid <= 1'b1;
          src_kind <= nxt.kind;
          src_code <= nxt.code;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Token monitor: compares every transfer with the oldest predicted token.
  always @(posedge clk) begin : token_monitor
    token_rec_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (token_q.size() == 0) begin
          mismatches++;
          $error("unexpected token: kind %0d offset %0d", tok_kind, tok_offset);
        end else begin
          want = token_q.pop_front();
          check_field("token_kind", want.kind, tok_kind);
          check_field("keyword_code", want.keyword, tok_keyword);
          check_field("is_number", want.is_number, tok_is_number);
          check_field("start_offset", want.offset, tok_offset);
          check_field("line_number", want.line, tok_line);
          check_field("column_number", want.column, tok_column);
          check_field("token_length", want.length, tok_length);
          check_field("length_overflow", want.overflow, tok_overflow);
          check_field("last_result", want.last, tok_last);
        end
      end
      out_ready <= quiet || ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= StallLimit) begin
        $display("FAIL assembly_source_tokenizer");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Keywords, punctuation, bare hex prefixes, invalid bytes, a comment, eof with a word open.
    push_text("MOV ADD,SUB:DIV[INT]");
    push_byte(8'hFF);
    push_text("0X 0x;");
    push_byte(8'h80);
    push_byte(ast_pkg::CharNewline);
    push_byte(8'h00);
    push_text("09a _z");
    push_eof();
    wait_drained();

    // A word just past the length limit.
    push_long_word(256, 1'b0);
    push_byte(ast_pkg::CharComma);
    push_eof();
    wait_drained();

    while (random_items < RandomItems / 2) push_piece();
    wait_drained();
    quiet = 1'b1;
    while (random_items < 3 * RandomItems / 4) push_piece();
    wait_drained();
    quiet = 1'b0;
    while (random_items < RandomItems) push_piece();
    push_eof();
    wait_drained();

    repeat (8) @(negedge clk);
    if ((mismatches == 0) && (token_q.size() == 0)) begin
      $display("PASS assembly_source_tokenizer");
    end else begin
      $display("FAIL assembly_source_tokenizer");
    end
    $finish;
  end

endmodule

### assembly_source_tokenizer.f
hw/rtl/ast_pkg.sv
hw/rtl/ast_front.sv
hw/rtl/ast_queue.sv
hw/rtl/ast_back.sv
hw/rtl/assembly_source_tokenizer.sv
tb/assembly_source_tokenizer_test.sv
